[hdl/cbts_pkg.sv]
// Shared widths, limits, codes and types for the CAN bit-timing solver.
// Standalone package; used by every module in the hdl folder.
`timescale 1ns / 1ps

package cbts_pkg;

    // Field and datapath widths
    localparam int DATA_W      = 32;
    localparam int BAUD_W      = 24;
    localparam int SP_W        = 10;
    localparam int PC_W        = 10;
    localparam int S1C_W       = 4;
    localparam int S2C_W       = 3;
    localparam int ATT_W       = 2;
    localparam int IN_TDATA_W  = ((BAUD_W + SP_W + 7) / 8) * 8;
    localparam int OUT_PAY_W   = PC_W + S1C_W + S2C_W + ATT_W;
    localparam int OUT_TDATA_W = ((OUT_PAY_W + 7) / 8) * 8;

    // Timing limits
    localparam int PRESCALER_MAX = 1024;
    localparam int SEG1_MAX      = 16;
    localparam int SEG2_MAX      = 8;

    typedef logic [DATA_W-1:0] word_t;

    localparam word_t CLOCK_HZ_RST = word_t'(72000000);
    localparam word_t WORD_ONE     = word_t'(1);
    localparam word_t P_MIN        = word_t'(2);
    // Quotient ts1 / p equals segment 1 plus one
    localparam word_t Q1_MIN       = word_t'(2);

    // Split attempts in the order they are tried
    typedef enum logic [ATT_W-1:0] {
        ATT_NOM   = 2'd0,
        ATT_PLUS  = 2'd1,
        ATT_MINUS = 2'd2
    } attempt_t;

endpackage

[hdl/cbts_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle, W-bit quotient.
// Depends on cbts_pkg for the default width.
`timescale 1ns / 1ps

module cbts_div
    import cbts_pkg::*;
#(
    parameter int W = DATA_W
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     rem_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [W:0]   shifted;
    logic [W:0]   diff;
    logic         fits;
    logic [W-1:0] rem_next;
    logic [W-1:0] quo_next;

    // Shift in the next dividend bit and try a subtract
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[W-1]};
        diff     = shifted - {1'b0, dsr_reg};
        fits     = (shifted >= {1'b0, dsr_reg});
        rem_next = fits ? diff[W-1:0] : shifted[W-1:0];
        quo_next = {quo_reg[W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dsr_reg  <= divisor;
                cnt_reg  <= CNT_W'(W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[hdl/cbts_mul.sv]
// Shift-add multiplier: one multiplier bit per cycle, returns floor(a * b / 2^M).
// Depends on cbts_pkg for the default widths.
`timescale 1ns / 1ps

module cbts_mul
    import cbts_pkg::*;
#(
    parameter int W = DATA_W,
    parameter int M = SP_W
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] mcand,
    input  logic [M-1:0] mplier,
    output logic         done,
    output logic [W-1:0] product_hi
);

    localparam int CNT_W = $clog2(M + 1);

    logic [W+M-1:0]   prod_reg;
    logic [W-1:0]     mcd_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [W:0]     upper_sum;
    logic [W+M-1:0] prod_next;

    // Add the multiplicand on a set low bit, then shift the product right
    always_comb
    begin
        upper_sum = {1'b0, prod_reg[W+M-1:M]} + (prod_reg[0] ? {1'b0, mcd_reg} : '0);
        prod_next = {upper_sum, prod_reg[M-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                prod_reg <= {{W{1'b0}}, mplier};
                mcd_reg  <= mcand;
                cnt_reg  <= CNT_W'(M);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                prod_reg <= prod_next;
                cnt_reg  <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done       = done_reg;
    assign product_hi = prod_reg[W+M-1:M];

endmodule

[hdl/cbts_gcd.sv]
// Binary greatest-common-divisor unit: one halving or subtract step per cycle,
// then one left shift per cycle to restore the common power of two. Uses cbts_pkg.
`timescale 1ns / 1ps

module cbts_gcd
    import cbts_pkg::*;
#(
    parameter int W = DATA_W
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] x,
    input  logic [W-1:0] y,
    output logic         done,
    output logic [W-1:0] result
);

    localparam int K_W = $clog2(W);

    typedef enum logic [1:0] {
        G_IDLE,
        G_RUN,
        G_SHIFT
    } gcd_state_t;

    gcd_state_t     state_reg;
    logic [W-1:0]   a_reg;
    logic [W-1:0]   b_reg;
    logic [K_W-1:0] k_reg;
    logic           done_reg;

    logic [W-1:0] diff_ab;
    logic [W-1:0] diff_ba;

    assign diff_ab = a_reg - b_reg;
    assign diff_ba = b_reg - a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= G_IDLE;
            done_reg  <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                G_IDLE:
                begin
                    if (start)
                    begin
                        a_reg     <= x;
                        b_reg     <= y;
                        k_reg     <= '0;
                        state_reg <= G_RUN;
                    end
                end
                G_RUN:
                begin
                    // Reduce until one operand reaches zero
                    if (a_reg == '0)
                    begin
                        a_reg     <= b_reg;
                        state_reg <= G_SHIFT;
                    end
                    else if (b_reg == '0)
                    begin
                        state_reg <= G_SHIFT;
                    end
                    else if (!a_reg[0] && !b_reg[0])
                    begin
                        a_reg <= {1'b0, a_reg[W-1:1]};
                        b_reg <= {1'b0, b_reg[W-1:1]};
                        k_reg <= k_reg + K_W'(1);
                    end
                    else if (!a_reg[0])
                    begin
                        a_reg <= {1'b0, a_reg[W-1:1]};
                    end
                    else if (!b_reg[0])
                    begin
                        b_reg <= {1'b0, b_reg[W-1:1]};
                    end
                    else if (a_reg >= b_reg)
                    begin
                        a_reg <= {1'b0, diff_ab[W-1:1]};
                    end
                    else
                    begin
                        b_reg <= {1'b0, diff_ba[W-1:1]};
                    end
                end
                G_SHIFT:
                begin
                    // Put back the common factors of two
                    if (k_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= G_IDLE;
                    end
                    else
                    begin
                        a_reg <= {a_reg[W-2:0], 1'b0};
                        k_reg <= k_reg - K_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= G_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = a_reg;

endmodule

[hdl/can_bit_timing_solver.sv]
// Top level of the CAN bit-timing solver: control sequencer, clock register,
// output register. Uses cbts_pkg, cbts_div, cbts_mul and cbts_gcd.
//
//  Channel   Direction  Handshake                      Word
//  s_axis    in         s_axis_tvalid / s_axis_tready  baud_rate, sample_point
//  m_axis    out        m_axis_tvalid / m_axis_tready  codes in tdata, ok in tuser
//  cfg       in         cfg_wr_en                      clock_hz
//
// A zero rate skips all arithmetic and goes to the finish state. Otherwise q = clock_hz / baud_rate
// (on the 32-step serial divider) and ts1 (on the 10-step shift-add) are found first; each
// split attempt then skips the GCD and divides when ts1 is out of range, or else runs a
// binary GCD and up to two divides. One word is worked on at a time; the next word is taken
// as soon as the result sits in the output register, even while that result waits on
// m_axis_tready. Reset clears control and loads 72000000 Hz.
`timescale 1ns / 1ps

module can_bit_timing_solver
    import cbts_pkg::*;
#(
    parameter int PRESCALER_LIM = PRESCALER_MAX,
    parameter int SEG1_LIM      = SEG1_MAX,
    parameter int SEG2_LIM      = SEG2_MAX
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [DATA_W-1:0]      cfg_wr_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [23:0] baud_rate, [33:24] sample_point, [39:34] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [9:0] prescaler_code, [13:10] seg1_code, [16:14] seg2_code,
    // [18:17] attempt_used, [23:19] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] ok
    output logic [0:0]             m_axis_tuser
);

    localparam word_t P_MAX  = word_t'(PRESCALER_LIM);
    localparam word_t Q1_MAX = word_t'(SEG1_LIM + 1);
    localparam word_t Q2_MAX = word_t'(SEG2_LIM);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_Q,
        S_MUL,
        S_TRY,
        S_GCD,
        S_DIV1,
        S_DIV2,
        S_NEXT,
        S_FINISH
    } state_t;

    state_t           state_reg;
    word_t            clock_hz_reg;
    logic [SP_W-1:0]  sp_reg;
    word_t            q_reg;
    word_t            t1_reg;
    word_t            tt_reg;
    word_t            t2_reg;
    word_t            p_reg;
    attempt_t         att_reg;
    logic [S1C_W-1:0] s1c_reg;
    logic [S2C_W-1:0] s2c_reg;
    logic             ok_reg;

    logic             div_start_reg;
    word_t            div_a_reg;
    word_t            div_b_reg;
    logic             mul_start_reg;
    logic             gcd_start_reg;

    logic                   m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;
    logic                   m_ok_reg;

    logic  div_done;
    word_t div_quo;
    logic  mul_done;
    word_t mul_hi;
    logic  gcd_done;
    word_t gcd_res;

    word_t            trial;
    logic             trial_bad;
    logic [OUT_PAY_W-1:0] payload;
    logic [BAUD_W-1:0] in_baud;
    logic [SP_W-1:0]  in_sp;

    assign in_baud = s_axis_tdata[BAUD_W-1:0];
    assign in_sp   = s_axis_tdata[BAUD_W+SP_W-1:BAUD_W];

    // Shared serial divider for q, ts1 / p and ts2 / p
    cbts_div #(.W(DATA_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_a_reg),
        .divisor  (div_b_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    cbts_mul #(.W(DATA_W), .M(SP_W)) u_mul (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (mul_start_reg),
        .mcand      (q_reg),
        .mplier     (sp_reg),
        .done       (mul_done),
        .product_hi (mul_hi)
    );

    cbts_gcd #(.W(DATA_W)) u_gcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (gcd_start_reg),
        .x      (tt_reg),
        .y      (t2_reg),
        .done   (gcd_done),
        .result (gcd_res)
    );

    // Pick the split point for the current attempt
    always_comb
    begin
        case (att_reg)
            ATT_NOM:   trial = t1_reg;
            ATT_PLUS:  trial = t1_reg + WORD_ONE;
            ATT_MINUS: trial = t1_reg - WORD_ONE;
            default:   trial = t1_reg;
        endcase
        trial_bad = (trial == '0) || (trial >= q_reg);
    end

    // Pack the result codes, all zero on failure
    always_comb
    begin
        if (ok_reg)
        begin
            payload = {ATT_W'(att_reg), s2c_reg, s1c_reg, PC_W'(p_reg - WORD_ONE)};
        end
        else
        begin
            payload = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            clock_hz_reg  <= CLOCK_HZ_RST;
            div_start_reg <= 1'b0;
            mul_start_reg <= 1'b0;
            gcd_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            ok_reg        <= 1'b0;
            att_reg       <= ATT_NOM;
        end
        else
        begin
            div_start_reg <= 1'b0;
            mul_start_reg <= 1'b0;
            gcd_start_reg <= 1'b0;

            if (cfg_wr_en)
            begin
                clock_hz_reg <= cfg_wr_data;
            end

            // Drop the result once taken
            if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        sp_reg   <= in_sp;
                        att_reg  <= ATT_NOM;
                        ok_reg   <= 1'b0;
                        if (in_baud == '0)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            div_a_reg     <= clock_hz_reg;
                            div_b_reg     <= word_t'(in_baud);
                            div_start_reg <= 1'b1;
                            state_reg     <= S_DIV_Q;
                        end
                    end
                end
                S_DIV_Q:
                begin
                    if (div_done)
                    begin
                        q_reg         <= div_quo;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    if (mul_done)
                    begin
                        t1_reg    <= mul_hi;
                        state_reg <= S_TRY;
                    end
                end
                S_TRY:
                begin
                    tt_reg <= trial;
                    if (trial_bad)
                    begin
                        state_reg <= S_NEXT;
                    end
                    else
                    begin
                        t2_reg        <= q_reg - trial;
                        gcd_start_reg <= 1'b1;
                        state_reg     <= S_GCD;
                    end
                end
                S_GCD:
                begin
                    if (gcd_done)
                    begin
                        p_reg <= gcd_res;
                        if ((gcd_res < P_MIN) || (gcd_res > P_MAX))
                        begin
                            state_reg <= S_NEXT;
                        end
                        else
                        begin
                            div_a_reg     <= tt_reg;
                            div_b_reg     <= gcd_res;
                            div_start_reg <= 1'b1;
                            state_reg     <= S_DIV1;
                        end
                    end
                end
                S_DIV1:
                begin
                    // ts1 / p is segment 1 plus one
                    if (div_done)
                    begin
                        if ((div_quo < Q1_MIN) || (div_quo > Q1_MAX))
                        begin
                            state_reg <= S_NEXT;
                        end
                        else
                        begin
                            s1c_reg       <= S1C_W'(div_quo - Q1_MIN);
                            div_a_reg     <= t2_reg;
                            div_b_reg     <= p_reg;
                            div_start_reg <= 1'b1;
                            state_reg     <= S_DIV2;
                        end
                    end
                end
                S_DIV2:
                begin
                    if (div_done)
                    begin
                        if ((div_quo == '0) || (div_quo > Q2_MAX))
                        begin
                            state_reg <= S_NEXT;
                        end
                        else
                        begin
                            s2c_reg   <= S2C_W'(div_quo - WORD_ONE);
                            ok_reg    <= 1'b1;
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_NEXT:
                begin
                    // Advance to the next split, or give up
                    case (att_reg)
                        ATT_NOM:
                        begin
                            att_reg   <= ATT_PLUS;
                            state_reg <= S_TRY;
                        end
                        ATT_PLUS:
                        begin
                            if (t1_reg != '0)
                            begin
                                att_reg   <= ATT_MINUS;
                                state_reg <= S_TRY;
                            end
                            else
                            begin
                                state_reg <= S_FINISH;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_FINISH;
                        end
                    endcase
                end
                S_FINISH:
                begin
                    // Hold until the output register is free
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= OUT_TDATA_W'(payload);
                        m_ok_reg    <= ok_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_ok_reg;

endmodule
